@@ rtl/dda_pkg.sv @@
// ----------------------------------------------------------------------------
// dda_pkg
// Shared types, constants and the panel band remap for the line rasteriser.
// ----------------------------------------------------------------------------
package dda_pkg;

    // coordinate and output widths
    localparam int COORD_W = 6;
    localparam int COL_W   = 10;
    localparam int CFG_W   = 5;
    localparam int BAND_W  = 3;

    // module geometry: 8 rows per band
    localparam int BAND_SHIFT = 3;

    // configuration register indexes
    localparam logic CFG_TILES_ACROSS = 1'b0;
    localparam logic CFG_TILES_DOWN   = 1'b1;

    // input beat: one line request
    typedef struct packed {
        logic [COORD_W-1:0] start_x;
        logic [COORD_W-1:0] start_y;
        logic [COORD_W-1:0] end_x;
        logic [COORD_W-1:0] end_y;
        logic               pixel_on;
    } t_in_item;

    // output beat: one pixel
    typedef struct packed {
        logic [COORD_W-1:0] row;
        logic [COL_W-1:0]   column;
        logic               lit;
        logic               last_point;
    } t_out_item;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_EMIT
    } t_state;

    // band remap onto the tiled panel, column wraps to its width
    function automatic t_out_item f_remap(
        input logic [COORD_W-1:0] x,
        input logic [COORD_W-1:0] y,
        input logic [CFG_W-1:0]   tiles_across,
        input logic [CFG_W-1:0]   tiles_down,
        input logic               lit,
        input logic               last_point
    );
        t_out_item                 res;
        logic [BAND_W-1:0]         band;
        logic [CFG_W+BAND_W-1:0]   prod;
        logic [CFG_W+BAND_W+BAND_SHIFT-1:0] offs;
        band = y[COORD_W-1:BAND_SHIFT];
        prod = tiles_across * band;
        offs = {prod, {BAND_SHIFT{1'b0}}};
        res.lit        = lit;
        res.last_point = last_point;
        if ((band != '0) && (tiles_down > CFG_W'(1))) begin
            res.column = COL_W'({{(COL_W-COORD_W){1'b0}}, x} + COL_W'(offs));
            res.row    = {{(COORD_W-BAND_SHIFT){1'b0}}, y[BAND_SHIFT-1:0]};
        end else begin
            res.column = {{(COL_W-COORD_W){1'b0}}, x};
            res.row    = y;
        end
        return res;
    endfunction

endpackage

@@ rtl/dda_line_rasterizer_unit.sv @@
// ----------------------------------------------------------------------------
// dda_line_rasterizer_unit
// DDA line rasteriser: one shared restoring divider for the minor-axis
// increment, then a per-pixel accumulator feeding the panel band remap.
// ----------------------------------------------------------------------------
//  channel   | direction | handshake                  | beat
//  ----------+-----------+----------------------------+--------------------
//  in        | input     | i_in_valid / o_in_ready    | t_in_item
//  out       | output    | o_out_valid / i_out_ready  | t_out_item
//  cfg       | input     | i_cfg_we (no wait)         | index + 5-bit data
//
//  A line is taken only in idle, runs the divider when the two deltas differ,
//  then emits steps + 1 pixels, one per cycle while the output is not stalled.
//  Reset is synchronous, active low, and clears the sequencer, the output
//  valid and both tile registers. A stalled output holds the emit loop.
// ----------------------------------------------------------------------------
module dda_line_rasterizer_unit #(
    parameter int COORD_MAX = 63,
    parameter int FRAC_BITS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  dda_pkg::t_in_item              i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output dda_pkg::t_out_item             o_out_data,
    input  logic                           i_cfg_we,
    input  logic                           i_cfg_index,
    input  logic [dda_pkg::CFG_W-1:0]      i_cfg_data
);
    import dda_pkg::*;

    localparam int INC_W = FRAC_BITS + 1;
    localparam int ACC_W = FRAC_BITS + COORD_W;
    localparam int POS_W = FRAC_BITS + COORD_W + 1;
    localparam int CNT_W = $clog2(FRAC_BITS + 1);
    localparam logic [COORD_W-1:0] CMAX      = COORD_W'(COORD_MAX);
    localparam logic [INC_W-1:0]   INC_ONE   = INC_W'(1) << FRAC_BITS;
    localparam logic [CNT_W-1:0]   DIV_LAST  = CNT_W'(FRAC_BITS - 1);

    // configuration
    logic [CFG_W-1:0] r_tiles_across;
    logic [CFG_W-1:0] r_tiles_down;

    // sequencer and line state
    t_state              r_state, n_state;
    logic [COORD_W-1:0]  r_x1, n_x1, r_y1, n_y1, r_x2, n_x2, r_y2, n_y2;
    logic                r_xneg, n_xneg, r_yneg, n_yneg;
    logic                r_x_major, n_x_major;
    logic                r_on, n_on;
    logic [COORD_W-1:0]  r_steps, n_steps;
    logic [COORD_W-1:0]  r_rem, n_rem;
    logic [FRAC_BITS-1:0] r_quot, n_quot;
    logic [CNT_W-1:0]    r_div_cnt, n_div_cnt;
    logic [INC_W-1:0]    r_inc_x, n_inc_x, r_inc_y, n_inc_y;
    logic [ACC_W-1:0]    r_acc_x, n_acc_x, r_acc_y, n_acc_y;
    logic [COORD_W-1:0]  r_k, n_k;

    // output register
    logic                r_out_valid, n_out_valid;
    t_out_item           r_out, n_out;

    // request decode
    logic [COORD_W-1:0]  c_x1, c_y1, c_x2, c_y2, c_adx, c_ady, c_steps;
    logic                c_xneg, c_yneg;

    // divider step
    logic [COORD_W:0]    c_rem_sh;
    logic                c_ge;
    logic [FRAC_BITS-1:0] c_quot;

    // pixel position
    logic [POS_W-1:0]    c_px, c_py;
    logic                c_in_acc, c_out_free;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign c_in_acc    = i_in_valid && o_in_ready;
    assign c_out_free  = !r_out_valid || i_out_ready;

    // clamp and deltas of the incoming request
    always_comb begin
        c_x1   = (i_in_data.start_x > CMAX) ? CMAX : i_in_data.start_x;
        c_y1   = (i_in_data.start_y > CMAX) ? CMAX : i_in_data.start_y;
        c_x2   = (i_in_data.end_x   > CMAX) ? CMAX : i_in_data.end_x;
        c_y2   = (i_in_data.end_y   > CMAX) ? CMAX : i_in_data.end_y;
        c_xneg = c_x2 < c_x1;
        c_yneg = c_y2 < c_y1;
        c_adx  = c_xneg ? (c_x1 - c_x2) : (c_x2 - c_x1);
        c_ady  = c_yneg ? (c_y1 - c_y2) : (c_y2 - c_y1);
        c_steps = (c_adx >= c_ady) ? c_adx : c_ady;
    end

    // one restoring divider step on the minor delta
    always_comb begin
        c_rem_sh = {r_rem, 1'b0};
        c_ge     = c_rem_sh >= {1'b0, r_steps};
        c_quot   = {r_quot[FRAC_BITS-2:0], c_ge};
    end

    // current positions from the accumulators
    always_comb begin
        c_px = r_xneg ? ({1'b0, r_x1, {FRAC_BITS{1'b0}}} - {1'b0, r_acc_x})
                      : ({1'b0, r_x1, {FRAC_BITS{1'b0}}} + {1'b0, r_acc_x});
        c_py = r_yneg ? ({1'b0, r_y1, {FRAC_BITS{1'b0}}} - {1'b0, r_acc_y})
                      : ({1'b0, r_y1, {FRAC_BITS{1'b0}}} + {1'b0, r_acc_y});
    end

    // sequencer: next state and datapath updates
    always_comb begin
        n_state     = r_state;
        n_x1        = r_x1;
        n_y1        = r_y1;
        n_x2        = r_x2;
        n_y2        = r_y2;
        n_xneg      = r_xneg;
        n_yneg      = r_yneg;
        n_x_major   = r_x_major;
        n_on        = r_on;
        n_steps     = r_steps;
        n_rem       = r_rem;
        n_quot      = r_quot;
        n_div_cnt   = r_div_cnt;
        n_inc_x     = r_inc_x;
        n_inc_y     = r_inc_y;
        n_acc_x     = r_acc_x;
        n_acc_y     = r_acc_y;
        n_k         = r_k;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        unique case (r_state)
            ST_IDLE: begin
                if (c_in_acc) begin
                    n_x1      = c_x1;
                    n_y1      = c_y1;
                    n_x2      = c_x2;
                    n_y2      = c_y2;
                    n_xneg    = c_xneg;
                    n_yneg    = c_yneg;
                    n_x_major = c_adx >= c_ady;
                    n_on      = i_in_data.pixel_on;
                    n_steps   = c_steps;
                    n_rem     = (c_adx >= c_ady) ? c_ady : c_adx;
                    n_quot    = '0;
                    n_div_cnt = '0;
                    n_inc_x   = INC_ONE;
                    n_inc_y   = INC_ONE;
                    n_acc_x   = '0;
                    n_acc_y   = '0;
                    n_k       = '0;
                    // equal deltas or a single point need no division
                    if ((c_steps == '0) || (c_adx == c_ady)) begin
                        n_state = ST_EMIT;
                    end else begin
                        n_state = ST_DIVIDE;
                    end
                end
            end
            ST_DIVIDE: begin
                n_rem     = c_ge ? COORD_W'(c_rem_sh - {1'b0, r_steps})
                                 : c_rem_sh[COORD_W-1:0];
                n_quot    = c_quot;
                n_div_cnt = r_div_cnt + CNT_W'(1);
                if (r_div_cnt == DIV_LAST) begin
                    if (r_x_major) begin
                        n_inc_y = {1'b0, c_quot};
                    end else begin
                        n_inc_x = {1'b0, c_quot};
                    end
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (c_out_free) begin
                    n_out_valid = 1'b1;
                    if (r_k != r_steps) begin
                        n_out   = f_remap(c_px[FRAC_BITS+COORD_W-1:FRAC_BITS],
                                          c_py[FRAC_BITS+COORD_W-1:FRAC_BITS],
                                          r_tiles_across, r_tiles_down,
                                          r_on, 1'b0);
                        n_acc_x = r_acc_x + ACC_W'(r_inc_x);
                        n_acc_y = r_acc_y + ACC_W'(r_inc_y);
                        n_k     = r_k + COORD_W'(1);
                    end else begin
                        // exact end point closes the line
                        n_out   = f_remap(r_x2, r_y2, r_tiles_across,
                                          r_tiles_down, r_on, 1'b1);
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tiles_across <= '0;
            r_tiles_down   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_TILES_ACROSS: r_tiles_across <= i_cfg_data;
                CFG_TILES_DOWN:   r_tiles_down   <= i_cfg_data;
                default:          r_tiles_down   <= r_tiles_down;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_x1      <= n_x1;
        r_y1      <= n_y1;
        r_x2      <= n_x2;
        r_y2      <= n_y2;
        r_xneg    <= n_xneg;
        r_yneg    <= n_yneg;
        r_x_major <= n_x_major;
        r_on      <= n_on;
        r_steps   <= n_steps;
        r_rem     <= n_rem;
        r_quot    <= n_quot;
        r_div_cnt <= n_div_cnt;
        r_inc_x   <= n_inc_x;
        r_inc_y   <= n_inc_y;
        r_acc_x   <= n_acc_x;
        r_acc_y   <= n_acc_y;
        r_k       <= n_k;
        r_out     <= n_out;
    end

    // checks
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("block ready straight after taking a line");

    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIVIDE) |-> (r_div_cnt <= DIV_LAST))
        else $error("divider ran past its last step");

    a_emit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> (r_k <= r_steps))
        else $error("pixel count beyond step count");

    a_last_ends_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT && c_out_free && r_k == r_steps) |=>
            (o_out_valid && o_out_data.last_point && o_in_ready))
        else $error("end point not flagged as last beat");

endmodule

@@ test/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the DDA line rasteriser: line requests go in from a
// queue, every pixel beat that comes out is checked in order against a
// fixed-point line walker and band remap kept in the bench, over a range of
// tile settings with random idling on both channels.
// ----------------------------------------------------------------------------
module tb;
    import dda_pkg::*;

    localparam int COORD_LIMIT = 63;
    localparam int FRAC        = 16;
    localparam int SETTLE      = 100;

    // clock and reset
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    always #10 i_clk = ~i_clk;

    // block ports
    logic               i_in_valid  = 1'b0;
    logic               o_in_ready;
    t_in_item           i_in_data   = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    t_out_item          o_out_data;
    logic               i_cfg_we    = 1'b0;
    logic               i_cfg_index = CFG_TILES_ACROSS;
    logic [CFG_W-1:0]   i_cfg_data  = '0;

    // bench copy of the tile registers
    logic [CFG_W-1:0]   tiles_across_copy = '0;
    logic [CFG_W-1:0]   tiles_down_copy   = '0;

    // lines waiting to be offered and pixels waiting to be seen
    t_in_item           line_queue[$];
    t_out_item          pixel_expect[$];

    int unsigned        lines_queued   = 0;
    int unsigned        lines_taken    = 0;
    int unsigned        pixels_checked = 0;
    int unsigned        fail_count     = 0;
    int unsigned        settings_run   = 0;
    int unsigned        send_gap       = 0;
    int unsigned        recv_gap       = 0;
    int unsigned        hold_left      = 0;
    bit                 hold_kick      = 1'b0;
    bit                 calm           = 1'b0;

    dda_line_rasterizer_unit #(
        .COORD_MAX (COORD_LIMIT),
        .FRAC_BITS (FRAC)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // idle length: mostly short, now and then long
    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm)
            return 0;
        if (r < 45)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 20);
        return $urandom_range(40, 120);
    endfunction

    function automatic int unsigned clamp_coord(input logic [COORD_W-1:0] v);
        return (int'(v) > COORD_LIMIT) ? COORD_LIMIT : int'(v);
    endfunction

    // place a logical pixel on the tiled panel
    function automatic t_out_item panel_map(input int unsigned x, input int unsigned y,
                                            input logic on, input logic last);
        t_out_item   px;
        int unsigned col;
        int unsigned r;
        int unsigned band;
        col = x;
        r   = y;
        if (y > 7 && tiles_down_copy > 1) begin
            band = y / 8;
            col  = x + int'(tiles_across_copy) * 8 * band;
            r    = y - band * 8;
        end
        px.row        = COORD_W'(r);
        px.column     = COL_W'(col);
        px.lit        = on;
        px.last_point = last;
        return px;
    endfunction

    // walk the line in fixed point and queue every pixel it produces
    task automatic rasterise_line(input t_in_item ln);
        int unsigned x1, y1, x2, y2;
        int unsigned adx, ady, steps, incx, incy;
        int unsigned bx, by, px, py;
        bit          xneg, yneg;
        x1    = clamp_coord(ln.start_x);
        y1    = clamp_coord(ln.start_y);
        x2    = clamp_coord(ln.end_x);
        y2    = clamp_coord(ln.end_y);
        xneg  = x2 < x1;
        yneg  = y2 < y1;
        adx   = xneg ? x1 - x2 : x2 - x1;
        ady   = yneg ? y1 - y2 : y2 - y1;
        steps = (adx >= ady) ? adx : ady;
        if (steps > 0) begin
            incx = (adx << FRAC) / steps;
            incy = (ady << FRAC) / steps;
            bx   = x1 << FRAC;
            by   = y1 << FRAC;
            for (int unsigned k = 0; k < steps; k++) begin
                px = xneg ? bx - k * incx : bx + k * incx;
                py = yneg ? by - k * incy : by + k * incy;
                pixel_expect.push_back(panel_map(px >> FRAC, py >> FRAC,
                                                 ln.pixel_on, 1'b0));
            end
        end
        pixel_expect.push_back(panel_map(x2, y2, ln.pixel_on, 1'b1));
    endtask

    task automatic flag_mismatch(input string msg);
        fail_count++;
        $display("%0t mismatch: %s", $realtime, msg);
    endtask

    // compare one pixel beat with the oldest expectation
    task automatic check_pixel(input t_out_item got);
        t_out_item want;
        if (pixel_expect.size() == 0) begin
            flag_mismatch($sformatf("stray pixel row %0d column %0d", got.row, got.column));
            return;
        end
        want = pixel_expect.pop_front();
        pixels_checked++;
        if (got.row !== want.row)
            flag_mismatch($sformatf("row %0d, wanted %0d", got.row, want.row));
        if (got.column !== want.column)
            flag_mismatch($sformatf("column %0d, wanted %0d", got.column, want.column));
        if (got.lit !== want.lit)
            flag_mismatch($sformatf("lit %b, wanted %b", got.lit, want.lit));
        if (got.last_point !== want.last_point)
            flag_mismatch($sformatf("last_point %b, wanted %b",
                                    got.last_point, want.last_point));
    endtask

    // input driver: one line per beat from the queue
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                rasterise_line(i_in_data);
                lines_taken++;
            end
            if (!(i_in_valid && !o_in_ready)) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_in_valid <= 1'b0;
                end else if (line_queue.size() > 0) begin
                    i_in_data  <= line_queue.pop_front();
                    i_in_valid <= 1'b1;
                    send_gap   = idle_len();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // output monitor: checks beats and throttles ready
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready)
                check_pixel(o_out_data);
            if (hold_kick) begin
                hold_kick = 1'b0;
                hold_left = 600;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
                if ($urandom_range(0, 2) == 0)
                    recv_gap = idle_len();
            end
        end
    end

    task automatic queue_line(input int unsigned sx, input int unsigned sy,
                              input int unsigned ex, input int unsigned ey,
                              input logic on);
        t_in_item ln;
        ln.start_x  = COORD_W'(sx);
        ln.start_y  = COORD_W'(sy);
        ln.end_x    = COORD_W'(ex);
        ln.end_y    = COORD_W'(ey);
        ln.pixel_on = on;
        line_queue.push_back(ln);
        lines_queued++;
    endtask

    // corners, single points, axis lines, diagonals and shallow slopes
    task automatic queue_directed();
        queue_line(0, 0, 0, 0, 1'b1);
        queue_line(63, 63, 63, 63, 1'b0);
        queue_line(0, 0, 63, 0, 1'b1);
        queue_line(63, 0, 0, 0, 1'b0);
        queue_line(0, 0, 0, 63, 1'b1);
        queue_line(0, 63, 0, 0, 1'b1);
        queue_line(0, 0, 63, 63, 1'b1);
        queue_line(63, 63, 0, 0, 1'b0);
        queue_line(0, 0, 63, 1, 1'b1);
        queue_line(63, 0, 0, 62, 1'b1);
        queue_line(5, 60, 60, 3, 1'b0);
        queue_line(10, 7, 11, 40, 1'b1);
    endtask

    // random line, biased towards points, axis lines and the left and right panel edges
    task automatic queue_random();
        int unsigned sx, sy, ex, ey, pick;
        sx   = $urandom_range(0, 63);
        sy   = $urandom_range(0, 63);
        ex   = $urandom_range(0, 63);
        ey   = $urandom_range(0, 63);
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
            ex = sx;
            ey = sy;
        end else if (pick == 1) begin
            ey = sy;
        end else if (pick == 2) begin
            ex = sx;
        end else if (pick == 3) begin
            sx = $urandom_range(0, 1) ? 63 : 0;
            ex = $urandom_range(0, 1) ? 63 : 0;
        end
        queue_line(sx, sy, ex, ey, 1'(($urandom)));
    endtask

    task automatic write_tiles(input int unsigned across, input int unsigned down);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_TILES_ACROSS;
        i_cfg_data  <= CFG_W'(across);
        @(posedge i_clk);
        i_cfg_index <= CFG_TILES_DOWN;
        i_cfg_data  <= CFG_W'(down);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        tiles_across_copy = CFG_W'(across);
        tiles_down_copy   = CFG_W'(down);
        settings_run++;
    endtask

    // wait for every line to be taken and every pixel seen, then settle
    task automatic drain(input int unsigned max_cycles);
        int unsigned n;
        n = 0;
        while ((lines_taken != lines_queued || pixel_expect.size() != 0) && n < max_cycles) begin
            @(posedge i_clk);
            n++;
        end
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // test sequence
    initial begin
        int unsigned across_set[6];
        int unsigned down_set[6];
        across_set = '{4, 31, 0, 16, 1, 0};
        down_set   = '{4, 31, 16, 1, 2, 0};
        across_set[5] = $urandom_range(0, 31);
        down_set[5]   = $urandom_range(0, 31);

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings, then the widest sensible panel
        queue_directed();
        drain(1000000);
        write_tiles(16, 16);
        queue_directed();
        drain(1000000);

        for (int p = 0; p < 6; p++) begin
            write_tiles(across_set[p], down_set[p]);
            calm = (p == 2);
            for (int i = 0; i < 25; i++)
                queue_random();
            // long output stall while the input side keeps offering
            if (p == 0)
                hold_kick = 1'b1;
            drain(1000000);
        end

        if (pixel_expect.size() != 0)
            flag_mismatch($sformatf("%0d pixels never came out", pixel_expect.size()));

        $display("%0d lines over %0d tile settings, %0d pixels checked",
                 lines_taken, settings_run + 1, pixels_checked);
        $display("covered points, axis lines, diagonals, output hold-off and idle gaps");
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // hang guard
    initial begin
        #200ms;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/dda_pkg.sv
rtl/dda_line_rasterizer_unit.sv
test/tb.sv
